/* src/assert_macros.svh */
// Assertion macros for the RTL files that check themselves.
// No dependencies; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLY(label, clock, reset_n, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (expr)) \
        else $error("assertion failed: implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clock, reset_n, cond, expr) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (expr)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* src/tbt_pkg.sv */
// Types, codes and constants of the thermistor beta temperature block.
// No dependencies; the design files and the testbench refer to it by scoped names.
package tbt_pkg;

    localparam int SAMPLE_W    = 12;
    localparam int SAMPLE_BITS = 12;
    localparam int RES_W       = 20;
    localparam int N_W         = RES_W + SAMPLE_W;
    localparam int DIV_W       = 60;
    localparam int DVS_W       = 48;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [SAMPLE_W-1:0] FULL_SCALE = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [RES_W-1:0]    R_LIMIT    = 20'd1000000;
    localparam logic signed [15:0]  ERR_TEMP_Q4 = -16'sd15984;
    localparam logic [29:0]         LN2_Q30    = 30'd744261118;
    localparam logic signed [58:0]  KELVIN_Q16 = 59'sd17901158;
    localparam logic [DIV_W-1:0]    T2_NUM     = 60'd100 << 40;
    localparam logic [DIV_W-1:0]    TK_NUM     = 60'd1 << 56;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_READ_ERR     = 2'd1;
    localparam logic [1:0] ST_SAMPLE_RANGE = 2'd2;
    localparam logic [1:0] ST_RES_RANGE    = 2'd3;

    localparam logic [1:0] REG_SERIES  = 2'd0;
    localparam logic [1:0] REG_NOMINAL = 2'd1;
    localparam logic [1:0] REG_BETA    = 2'd2;
    localparam logic [1:0] REG_TEMP    = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                read_ok;
    } tbt_in_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw_echo;
        logic [RES_W-1:0]    resistance_ohm;
        logic signed [15:0]  temp_q4;
        logic [1:0]          status;
    } tbt_out_t;

    typedef struct packed {
        logic [RES_W-1:0]   series_resistance;
        logic [RES_W-1:0]   ref_resistance;
        logic [15:0]        beta_value;
        logic signed [7:0]  nominal_temp_c;
    } tbt_cfg_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [SAMPLE_W-1:0] sample;
        logic [N_W-1:0]      n;
    } tbt_job_t;

endpackage

/* src/thermistor_beta_temperature.sv */
// Top level of the NTC thermistor beta-equation temperature block.
// Depends on tbt_pkg, tbt_front, tbt_fifo, tbt_back and assert_macros.svh.
//
//   channel  | handshake               | word
//   ---------+-------------------------+---------------------------------------
//   item     | push / full             | tbt_in_t: sample, read_ok
//   result   | pop / empty             | tbt_out_t: raw_echo, resistance, temp
//   config   | cfg_valid / cfg_ready   | cfg_index, cfg_data (ready always high)
//
// The front takes one word per cycle while full is low and queues it; the
// back takes one job at a time. A read error or zero sample skips the
// divider. A resistance out of range ends after the resistance divide. A
// full conversion runs four divides on the shared divider plus three log2
// passes of the squaring multiplier.
// Reset clears the control state and loads the register defaults; no
// clearing pass. full rises only when the queue and front register are full;
// a result waits in the output register while the back starts the next job.
`include "assert_macros.svh"

module thermistor_beta_temperature
#(
    parameter int QUEUE_DEPTH = tbt_pkg::QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  tbt_pkg::tbt_in_t          item,
    output logic                      empty,
    input  logic                      pop,
    output tbt_pkg::tbt_out_t         result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [tbt_pkg::RES_W-1:0] cfg_data
);

    tbt_pkg::tbt_cfg_t cfg_reg;
    tbt_pkg::tbt_job_t front_job, queue_job;
    logic              front_valid, queue_wr_ok, queue_rd_ok, back_take;
    logic              out_err, out_no_res, out_ok, beta_wr;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.series_resistance <= 20'd10000;
            cfg_reg.ref_resistance    <= 20'd10000;
            cfg_reg.beta_value        <= 16'd3950;
            cfg_reg.nominal_temp_c    <= 8'sd25;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tbt_pkg::REG_SERIES:  cfg_reg.series_resistance <= cfg_data;
                tbt_pkg::REG_NOMINAL: cfg_reg.ref_resistance    <= cfg_data;
                tbt_pkg::REG_BETA:    cfg_reg.beta_value        <= cfg_data[15:0];
                tbt_pkg::REG_TEMP:    cfg_reg.nominal_temp_c    <= cfg_data[7:0];
                default:              cfg_reg.series_resistance <= cfg_reg.series_resistance;
            endcase
        end
    end

    // Classify and form the resistance numerator.
    tbt_front u_front
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .item              (item),
        .series_resistance (cfg_reg.series_resistance),
        .job               (front_job),
        .job_valid         (front_valid),
        .job_ready         (queue_wr_ok)
    );

    // Decouple front and back.
    tbt_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_ok   (queue_wr_ok),
        .wr_data (front_job),
        .rd_en   (back_take),
        .rd_ok   (queue_rd_ok),
        .rd_data (queue_job)
    );

    // Iterate the beta equation and hold the result word.
    tbt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (queue_job),
        .job_valid (queue_rd_ok),
        .job_take  (back_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

    // Classify the waiting result word for the checks below.
    assign out_err    = !empty && result.status != tbt_pkg::ST_OK;
    assign out_no_res = !empty && (result.status == tbt_pkg::ST_READ_ERR
                                   || result.status == tbt_pkg::ST_SAMPLE_RANGE);
    assign out_ok     = !empty && result.status == tbt_pkg::ST_OK;
    assign beta_wr    = cfg_valid && cfg_index == tbt_pkg::REG_BETA;

    `ASSERT_IMPLY(a_err_temp, clk, rst_n, out_err, result.temp_q4 == tbt_pkg::ERR_TEMP_Q4)
    `ASSERT_IMPLY(a_no_res, clk, rst_n, out_no_res, result.resistance_ohm == '0 && result.raw_echo == '0)
    `ASSERT_IMPLY(a_ok_range, clk, rst_n, out_ok, result.resistance_ohm < tbt_pkg::R_LIMIT && result.raw_echo != '0)
    `ASSERT_NEXT(a_beta_write, clk, rst_n, beta_wr, cfg_reg.beta_value == $past(cfg_data[15:0]))

endmodule

/* src/tbt_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on tbt_pkg for the operand widths.
module tbt_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tbt_pkg::DIV_W-1:0]  dividend,
    input  logic [tbt_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [tbt_pkg::DIV_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(tbt_pkg::DIV_W + 1);

    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          done_reg;
    logic [tbt_pkg::DVS_W-1:0]     rem_reg, rem_next, div_reg;
    logic [tbt_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [tbt_pkg::DVS_W:0]       shifted;
    logic                          ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[tbt_pkg::DIV_W-1]};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? tbt_pkg::DVS_W'(shifted - {1'b0, div_reg})
                      : shifted[tbt_pkg::DVS_W-1:0];
        quo_next = {quo_reg[tbt_pkg::DIV_W-2:0], ge};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == CNT_W'(1));
            if (start)
                cnt_reg <= CNT_W'(tbt_pkg::DIV_W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* src/tbt_front.sv */
// Front stage: take input words, classify them and form the divider numerator.
// Depends on tbt_pkg.
module tbt_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  tbt_pkg::tbt_in_t              item,
    input  logic [tbt_pkg::RES_W-1:0]     series_resistance,
    output tbt_pkg::tbt_job_t             job,
    output logic                          job_valid,
    input  logic                          job_ready
);

    logic                        valid_reg;
    tbt_pkg::tbt_job_t           job_reg, job_next;
    logic [tbt_pkg::SAMPLE_W-1:0] s, diff;
    logic                        accept;

    assign full   = valid_reg && !job_ready;
    assign accept = push && !full;

    always_comb
    begin
        s    = item.sample & tbt_pkg::FULL_SCALE;
        diff = tbt_pkg::FULL_SCALE - s;
        job_next.sample = s;
        job_next.n      = {{tbt_pkg::SAMPLE_W{1'b0}}, series_resistance}
                        * {{tbt_pkg::RES_W{1'b0}}, diff};
        if (!item.read_ok)
            job_next.status = tbt_pkg::ST_READ_ERR;
        else if (s == '0)
            job_next.status = tbt_pkg::ST_SAMPLE_RANGE;
        else
            job_next.status = tbt_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (job_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

    assign job       = job_reg;
    assign job_valid = valid_reg;

endmodule

/* src/tbt_fifo.sv */
// Short job queue between the front and back stages.
// Depends on tbt_pkg for the job type.
module tbt_fifo
#(
    parameter int DEPTH = tbt_pkg::QUEUE_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    output logic              wr_ok,
    input  tbt_pkg::tbt_job_t wr_data,
    input  logic              rd_en,
    output logic              rd_ok,
    output tbt_pkg::tbt_job_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbt_pkg::tbt_job_t mem [DEPTH];
    logic [PTR_W-1:0]  wp_reg, rp_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_wr, do_rd;

    assign wr_ok   = cnt_reg != CNT_W'(DEPTH);
    assign rd_ok   = cnt_reg != '0;
    assign do_wr   = wr_en && wr_ok;
    assign do_rd   = rd_en && rd_ok;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
            if (do_rd)
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wp_reg] <= wr_data;
    end

endmodule

/* src/tbt_back.sv */
// Back stage: resistance divide, log2 by squaring, beta equation, result register.
// Depends on tbt_pkg and tbt_div.
module tbt_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  tbt_pkg::tbt_cfg_t    cfg,
    input  tbt_pkg::tbt_job_t    job,
    input  logic                 job_valid,
    output logic                 job_take,
    output tbt_pkg::tbt_out_t    result,
    output logic                 empty,
    input  logic                 pop
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DIV_R    = 4'd1;
    localparam logic [3:0] S_LOG_INIT = 4'd2;
    localparam logic [3:0] S_LOG_SQ   = 4'd3;
    localparam logic [3:0] S_MUL      = 4'd4;
    localparam logic [3:0] S_DIV_T1   = 4'd5;
    localparam logic [3:0] S_DIV_T2   = 4'd6;
    localparam logic [3:0] S_DIV_TK   = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    logic [3:0]                   state_reg, state_next;
    tbt_pkg::tbt_job_t            job_reg;
    tbt_pkg::tbt_out_t            pend_reg, pend_next, out_reg;
    logic                         out_valid_reg;
    logic [tbt_pkg::RES_W-1:0]    rint_reg, rint_next;
    logic [1:0]                   sel_reg, sel_next;
    logic [4:0]                   cnt_reg, cnt_next;
    logic [30:0]                  m_reg, m_next;
    logic [28:0]                  res_reg, res_next;
    logic signed [31:0]           lgd_reg, lgd_next;
    logic                         neg_reg, neg_next;
    logic [46:0]                  t1_reg, t1_next;

    logic                         div_start, div_done;
    logic [tbt_pkg::DIV_W-1:0]    div_a, div_q;
    logic [tbt_pkg::DVS_W-1:0]    div_b;

    logic [tbt_pkg::RES_W-1:0]    r0, rint_sat;
    logic [15:0]                  b;
    logic [31:0]                  log_v;
    logic [4:0]                   lead;
    logic [61:0]                  norm, sq;
    logic [31:0]                  sq_top;
    logic [28:0]                  res_new;
    logic [30:0]                  lgd_abs;
    logic [60:0]                  mag;
    logic signed [16:0]           denom;
    logic signed [48:0]           inv, inv_abs;
    logic signed [58:0]           tk_s, tq16, tq4w;
    logic signed [15:0]           tq4;
    logic                         out_free;

    tbt_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_free = !out_valid_reg || pop;
    assign result   = out_reg;
    assign empty    = !out_valid_reg;

    always_comb
    begin
        r0 = (cfg.ref_resistance == '0) ? tbt_pkg::RES_W'(1) : cfg.ref_resistance;
        b  = (cfg.beta_value == '0) ? 16'd1 : cfg.beta_value;
        rint_sat = (div_q >= tbt_pkg::DIV_W'(tbt_pkg::R_LIMIT))
                 ? tbt_pkg::R_LIMIT : div_q[tbt_pkg::RES_W-1:0];

        unique case (sel_reg)
            2'd0:    log_v = job_reg.n;
            2'd1:    log_v = {20'd0, job_reg.sample};
            default: log_v = {12'd0, r0};
        endcase
        lead = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (log_v[i])
                lead = 5'(i);
        end
        norm = {log_v, 30'd0} >> lead;

        sq      = {31'd0, m_reg} * {31'd0, m_reg};
        sq_top  = sq[61:30];
        res_new = res_reg | (29'(sq_top[31]) << cnt_reg);

        lgd_abs = lgd_reg[31] ? 31'(-lgd_reg) : lgd_reg[30:0];
        mag     = {30'd0, lgd_abs} * {31'd0, tbt_pkg::LN2_Q30};

        denom = 17'($signed({{9{cfg.nominal_temp_c[7]}}, cfg.nominal_temp_c}) * 17'sd100)
              + 17'sd27315;

        inv     = neg_reg ? $signed({15'd0, div_q[33:0]}) - $signed({2'd0, t1_reg})
                          : $signed({15'd0, div_q[33:0]}) + $signed({2'd0, t1_reg});
        inv_abs = inv[48] ? -inv : inv;

        // Sign of inv is held in sel bit 0; apply it to the stored quotient.
        tk_s = neg_reg ? $signed({2'd0, div_q[56:0]}) : $signed({2'd0, div_q[56:0]});
        tk_s = sel_reg[0] ? -tk_s : tk_s;
        tq16 = tk_s - tbt_pkg::KELVIN_Q16;
        tq4w = (tq16 + 59'sd2048) >>> 12;
        if (tq4w > 59'sd32767)
            tq4 = 16'sd32767;
        else if (tq4w < -59'sd32768)
            tq4 = -16'sd32768;
        else
            tq4 = tq4w[15:0];
    end

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        rint_next  = rint_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        m_next     = m_reg;
        res_next   = res_reg;
        lgd_next   = lgd_reg;
        neg_next   = neg_reg;
        t1_next    = t1_reg;
        job_take   = 1'b0;
        div_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    if (job.status != tbt_pkg::ST_OK)
                    begin
                        pend_next = '{raw_echo: '0, resistance_ohm: '0,
                                      temp_q4: tbt_pkg::ERR_TEMP_Q4, status: job.status};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_a      = tbt_pkg::DIV_W'(job.n);
                        div_b      = tbt_pkg::DVS_W'(job.sample);
                        state_next = S_DIV_R;
                    end
                end
            end
            S_DIV_R:
            begin
                if (div_done)
                begin
                    if (job_reg.n == '0 || div_q >= tbt_pkg::DIV_W'(tbt_pkg::R_LIMIT))
                    begin
                        pend_next = '{raw_echo: job_reg.sample, resistance_ohm: rint_sat,
                                      temp_q4: tbt_pkg::ERR_TEMP_Q4,
                                      status: tbt_pkg::ST_RES_RANGE};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rint_next  = rint_sat;
                        lgd_next   = '0;
                        sel_next   = 2'd0;
                        state_next = S_LOG_INIT;
                    end
                end
            end
            S_LOG_INIT:
            begin
                m_next     = norm[30:0];
                res_next   = {lead, 24'd0};
                cnt_next   = 5'd23;
                state_next = S_LOG_SQ;
            end
            S_LOG_SQ:
            begin
                // One squaring per fraction bit; renormalize when the square passes 2.
                m_next   = sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                res_next = res_new;
                if (cnt_reg == '0)
                begin
                    lgd_next = (sel_reg == 2'd0) ? lgd_reg + $signed({3'd0, res_new})
                                                 : lgd_reg - $signed({3'd0, res_new});
                    if (sel_reg == 2'd2)
                        state_next = S_MUL;
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_LOG_INIT;
                    end
                end
                else
                    cnt_next = cnt_reg - 5'd1;
            end
            S_MUL:
            begin
                neg_next   = lgd_reg[31];
                div_start  = 1'b1;
                div_a      = mag[tbt_pkg::DIV_W-1:0];
                div_b      = {18'd0, b, 14'd0};
                state_next = S_DIV_T1;
            end
            S_DIV_T1:
            begin
                if (div_done)
                begin
                    t1_next    = div_q[46:0];
                    div_start  = 1'b1;
                    div_a      = tbt_pkg::T2_NUM;
                    div_b      = {31'd0, denom};
                    state_next = S_DIV_T2;
                end
            end
            S_DIV_T2:
            begin
                if (div_done)
                begin
                    if (inv == '0)
                    begin
                        pend_next = '{raw_echo: job_reg.sample, resistance_ohm: rint_reg,
                                      temp_q4: 16'sd32767, status: tbt_pkg::ST_OK};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Reuse sel bit 0 to carry the sign of 1/T into the last step.
                        sel_next   = {1'b0, inv[48]};
                        div_start  = 1'b1;
                        div_a      = tbt_pkg::TK_NUM;
                        div_b      = inv_abs[tbt_pkg::DVS_W-1:0];
                        state_next = S_DIV_TK;
                    end
                end
            end
            S_DIV_TK:
            begin
                if (div_done)
                begin
                    pend_next = '{raw_echo: job_reg.sample, resistance_ohm: rint_reg,
                                  temp_q4: tq4, status: tbt_pkg::ST_OK};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (pop)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_take)
            job_reg <= job;
        if (state_reg == S_DONE && out_free)
            out_reg <= pend_reg;
        pend_reg <= pend_next;
        rint_reg <= rint_next;
        sel_reg  <= sel_next;
        cnt_reg  <= cnt_next;
        m_reg    <= m_next;
        res_reg  <= res_next;
        lgd_reg  <= lgd_next;
        neg_reg  <= neg_next;
        t1_reg   <= t1_next;
    end

endmodule

/* dv/thermistor_beta_temperature_tb.sv */
// Testbench for thermistor_beta_temperature: random and directed divider samples,
// checked word by word against a built-in fixed-point beta-equation predictor.
// Depends on tbt_pkg and the RTL under src/.
`timescale 1ns / 100ps

module thermistor_beta_temperature_tb;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic push;
    logic full;
    tbt_pkg::tbt_in_t item;
    logic empty;
    logic pop;
    tbt_pkg::tbt_out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [tbt_pkg::RES_W-1:0] cfg_data;

    // Samples waiting for the driver, and conversions waiting for the block.
    tbt_pkg::tbt_in_t sample_queue[$];
    tbt_pkg::tbt_out_t conversion_queue[$];

    // Predictor copy of the configuration registers.
    logic [tbt_pkg::RES_W-1:0] series_ohm;
    logic [tbt_pkg::RES_W-1:0] nominal_ohm;
    logic [15:0] beta_k;
    logic [7:0] nominal_c;

    int send_idle_pct;
    int take_idle_pct;
    int mismatches;
    int cycles;

    thermistor_beta_temperature u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // log2 of a positive integer as unsigned Q24; fraction bits come from
    // squaring a Q30 mantissa, each square truncated back to Q30.
    function automatic logic [63:0] log2_q24(input logic [63:0] v);
        int e;
        logic [63:0] m;
        logic [63:0] acc;
        e = 0;
        if (v == 0)
            return 0;
        while (e < 63 && (v >> (e + 1)) != 0)
            e++;
        if (e > 30)
            m = v >> (e - 30);
        else
            m = v << (30 - e);
        acc = 64'(e) << 24;
        for (int i = 23; i >= 0; i--)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                acc[i] = 1'b1;
                m = m >> 1;
            end
        end
        return acc;
    endfunction

    // Expected conversion of one sample word under the current registers.
    function automatic tbt_pkg::tbt_out_t thermistor_convert(input tbt_pkg::tbt_in_t w);
        logic [63:0] s;
        logic [63:0] n;
        logic [63:0] rint;
        logic [63:0] r0;
        logic [63:0] b;
        logic [63:0] mag;
        logic [63:0] t1;
        logic [63:0] tk;
        longint lgd;
        longint nt;
        longint t2;
        longint inv;
        longint tq16;
        longint tq4;
        bit neg;
        tbt_pkg::tbt_out_t r;
        r.raw_echo = '0;
        r.resistance_ohm = '0;
        r.temp_q4 = tbt_pkg::ERR_TEMP_Q4;
        s = 64'(w.sample) & 64'(tbt_pkg::FULL_SCALE);
        if (!w.read_ok)
        begin
            r.status = tbt_pkg::ST_READ_ERR;
            return r;
        end
        if (s == 0)
        begin
            r.status = tbt_pkg::ST_SAMPLE_RANGE;
            return r;
        end
        r.raw_echo = s[tbt_pkg::SAMPLE_W-1:0];
        n = 64'(series_ohm) * (64'(tbt_pkg::FULL_SCALE) - s);
        rint = n / s;
        if (rint > 64'(tbt_pkg::R_LIMIT))
            rint = 64'(tbt_pkg::R_LIMIT);
        r.resistance_ohm = rint[tbt_pkg::RES_W-1:0];
        if (n == 0 || n >= 64'(tbt_pkg::R_LIMIT) * s)
        begin
            r.status = tbt_pkg::ST_RES_RANGE;
            return r;
        end
        r0 = (nominal_ohm != 0) ? 64'(nominal_ohm) : 64'd1;
        b = (beta_k != 0) ? 64'(beta_k) : 64'd1;
        lgd = longint'(log2_q24(n)) - longint'(log2_q24(s)) - longint'(log2_q24(r0));
        neg = lgd < 0;
        mag = 64'(neg ? -lgd : lgd) * 64'(tbt_pkg::LN2_Q30);
        t1 = mag / (b << 14);
        nt = longint'($signed(nominal_c));
        t2 = longint'((64'd100 << 40) / 64'(100 * nt + 27315));
        inv = neg ? t2 - longint'(t1) : t2 + longint'(t1);
        if (inv == 0)
            tq4 = 32767;
        else
        begin
            tk = (64'd1 << 56) / 64'(inv < 0 ? -inv : inv);
            tq16 = (inv < 0 ? -longint'(tk) : longint'(tk)) - longint'(tbt_pkg::KELVIN_Q16);
            // round to nearest, ties upward
            tq4 = (tq16 + 2048) >>> 12;
            if (tq4 > 32767)
                tq4 = 32767;
            if (tq4 < -32768)
                tq4 = -32768;
        end
        r.temp_q4 = tq4[15:0];
        r.status = tbt_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
        mismatches++;
    endtask

    // Driver: advance to the next sample once the current word is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            item <= '0;
        end
        else if (!push || !full)
        begin
            if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item <= sample_queue.pop_front();
                push <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // Receiver: stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(99) >= take_idle_pct);
    end

    // Monitor: track register writes, predict on accept, check on pop.
    always @(posedge clk or negedge rst_n)
    begin
        tbt_pkg::tbt_out_t want;
        if (!rst_n)
        begin
            series_ohm <= 20'd10000;
            nominal_ohm <= 20'd10000;
            beta_k <= 16'd3950;
            nominal_c <= 8'd25;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tbt_pkg::REG_SERIES:  series_ohm <= cfg_data;
                    tbt_pkg::REG_NOMINAL: nominal_ohm <= cfg_data;
                    tbt_pkg::REG_BETA:    beta_k <= cfg_data[15:0];
                    tbt_pkg::REG_TEMP:    nominal_c <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (push && !full)
                conversion_queue.push_back(thermistor_convert(item));
            if (pop && !empty)
            begin
                if (conversion_queue.size() == 0)
                begin
                    $display("[%0t] result word with nothing expected", $time);
                    mismatches++;
                end
                else
                begin
                    want = conversion_queue.pop_front();
                    if (result.raw_echo !== want.raw_echo)
                        report_mismatch("raw_echo", want.raw_echo, result.raw_echo);
                    if (result.resistance_ohm !== want.resistance_ohm)
                        report_mismatch("resistance_ohm", want.resistance_ohm,
                                        result.resistance_ohm);
                    if (result.temp_q4 !== want.temp_q4)
                        report_mismatch("temp_q4", want.temp_q4, result.temp_q4);
                    if (result.status !== want.status)
                        report_mismatch("status", want.status, result.status);
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [tbt_pkg::RES_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_regs(input logic [tbt_pkg::RES_W-1:0] ser,
                             input logic [tbt_pkg::RES_W-1:0] nom,
                             input logic [15:0] beta, input logic signed [7:0] t0);
        write_reg(tbt_pkg::REG_SERIES, ser);
        write_reg(tbt_pkg::REG_NOMINAL, nom);
        write_reg(tbt_pkg::REG_BETA, tbt_pkg::RES_W'(beta));
        write_reg(tbt_pkg::REG_TEMP, tbt_pkg::RES_W'(t0));
    endtask

    // Hold until every queued sample is taken and every conversion is back.
    task automatic drain();
        while (sample_queue.size() != 0 || push || conversion_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input int s, input bit ok);
        tbt_pkg::tbt_in_t w;
        w.sample = tbt_pkg::SAMPLE_W'(s);
        w.read_ok = ok;
        sample_queue.push_back(w);
    endtask

    // Mostly valid samples over the full range; a share of extremes and read errors.
    task automatic queue_random(input int count);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
                queue_sample($urandom_range(4095), 1'b0);
            else if (pick < 9)
                queue_sample(0, 1'b1);
            else if (pick < 12)
                queue_sample(4095, 1'b1);
            else if (pick < 20)
                queue_sample($urandom_range(8) + ((pick & 1) ? 4087 : 1), 1'b1);
            else
                queue_sample($urandom_range(4095), 1'b1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = tbt_pkg::REG_SERIES;
        cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 16;
        take_idle_pct = 76;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, extremes and each error path.
        queue_sample(0, 1'b1);
        queue_sample(0, 1'b0);
        queue_sample(4095, 1'b0);
        queue_sample(4095, 1'b1);
        queue_sample(4094, 1'b1);
        queue_sample(1, 1'b1);
        queue_sample(2, 1'b1);
        queue_sample(10, 1'b1);
        queue_sample(2047, 1'b1);
        queue_sample(2048, 1'b1);
        queue_sample(1365, 1'b1);
        queue_sample(3000, 1'b1);
        queue_sample(12'hAAA, 1'b1);
        queue_sample(12'h555, 1'b1);
        queue_random(120);
        // pause the sender until everything is back
        drain();
        queue_random(110);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            send_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 76 : 0;
            take_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 16 : 0;
            case (ph)
                0: load_regs(20'd1, 20'd1, 16'd1, -8'sd40);
                1: load_regs(20'd1000000, 20'd1000000, 16'd65535, 8'sd125);
                2: load_regs(20'd0, 20'd0, 16'd0, -8'sd128);
                3: load_regs(20'hFFFFF, 20'hFFFFF, 16'd3435, 8'sd127);
                4: load_regs(20'($urandom_range(1, 1000000)), 20'($urandom_range(1, 1000000)),
                             16'($urandom_range(1, 65535)), 8'($urandom_range(0, 165) - 40));
                default: load_regs(20'd10000, 20'd10000, 16'd3950, 8'sd25);
            endcase
            queue_random(190);
            drain();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
